// File: rtl/core/wrp_pkg.sv
package wrp_pkg;

    localparam int MAX_CLUSTERS        = 16;
    localparam int MAX_CLUSTER_SERVERS = 256;
    localparam int MAX_REPLICAS        = 16;

    localparam int CL_AW   = $clog2(MAX_CLUSTERS);
    localparam int DECK_AW = $clog2(MAX_CLUSTER_SERVERS);

    localparam logic [31:0] HASH_XOR     = 32'hdead1234;
    localparam logic [31:0] HASH_MUL     = 32'd2654435761;
    localparam logic [31:0] DRAW_SALT    = 32'h00b90738;
    localparam logic [31:0] PICK_SALT    = 32'h00fea937;
    localparam logic [31:0] PICK_KEY_XOR = 32'd11;
    localparam logic [31:0] SEED_FIRST   = 32'd521288629;
    localparam logic [31:0] SEED_SECOND  = 32'd362436069;
    localparam logic [15:0] MWC_MUL_A    = 16'd18000;
    localparam logic [15:0] MWC_MUL_B    = 16'd18879;

    localparam logic       ACT_ADD   = 1'b0;
    localparam logic       ACT_PLACE = 1'b1;

    localparam logic [1:0] ST_SERVER   = 2'd0;
    localparam logic [1:0] ST_ADDED    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EMIT,
        S_ADD_MUL,
        S_ADD_WR,
        S_HASH,
        S_CL_RD,
        S_CL_WAIT,
        S_CL_SETUP,
        S_DR_RNG,
        S_DR_MUL,
        S_DR_CMP,
        S_DR_DONE,
        S_PK_SEED,
        S_PK_RNG,
        S_PK_MUL,
        S_PK_RD,
        S_PK_EMIT,
        S_NEXT
    } t_state;

    typedef struct packed {
        logic [8:0]  sz;
        logic [15:0] w;
        logic [11:0] sb;
        logic [27:0] wb;
    } t_centry;

    typedef struct packed {
        logic       we;
        logic [CL_AW-1:0] waddr;
        t_centry    wdata;
        logic [CL_AW-1:0] raddr;
    } t_ctab_ctl;

    typedef struct packed {
        logic        seed;
        logic        step;
        logic [31:0] a;
        logic [31:0] b;
    } t_rng_ctl;

    typedef struct packed {
        logic               clr;
        logic               we;
        logic [DECK_AW-1:0] waddr;
        logic [DECK_AW-1:0] wdata;
        logic               re;
        logic [DECK_AW-1:0] ra;
        logic [DECK_AW-1:0] rb;
    } t_deck_ctl;

endpackage

// File: rtl/core/wrp_ifs.sv
interface wrp_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] key;
    logic [4:0]  replica_count;
    logic [8:0]  cluster_servers;
    logic [15:0] server_weight;

    modport source (output valid, action, key, replica_count, cluster_servers,
                    server_weight, input ready);
    modport sink (input valid, action, key, replica_count, cluster_servers,
                  server_weight, output ready);
endinterface

interface wrp_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] server_index;
    logic [4:0]  cluster_total;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, server_index, cluster_total, status, last,
                    input ready);
    modport sink (input valid, server_index, cluster_total, status, last,
                  output ready);
endinterface

// File: rtl/core/wrp_ctab.sv
module wrp_ctab (
    input  logic               i_clk,
    input  wrp_pkg::t_ctab_ctl i_ctl,
    output wrp_pkg::t_centry   o_rdata
);

    wrp_pkg::t_centry mem [wrp_pkg::MAX_CLUSTERS];
    wrp_pkg::t_centry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= mem[i_ctl.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/wrp_mwc.sv
module wrp_mwc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrp_pkg::t_rng_ctl i_ctl,
    output logic [31:0]       o_rnd
);

    logic [31:0] r_first;
    logic [31:0] r_second;
    logic [31:0] n_first;
    logic [31:0] n_second;

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        if (i_ctl.seed) begin
            // a zero seed would lock the generator, take the reset constant
            n_first  = (i_ctl.a == 32'd0) ? wrp_pkg::SEED_FIRST : i_ctl.a;
            n_second = (i_ctl.b == 32'd0) ? wrp_pkg::SEED_SECOND : i_ctl.b;
        end else if (i_ctl.step) begin
            n_first  = wrp_pkg::MWC_MUL_A * r_first[15:0] + {16'd0, r_first[31:16]};
            n_second = wrp_pkg::MWC_MUL_B * r_second[15:0] + {16'd0, r_second[31:16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= wrp_pkg::SEED_FIRST;
            r_second <= wrp_pkg::SEED_SECOND;
        end else begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_rnd = {r_first[15:0], r_second[15:0]};

endmodule

// File: rtl/core/wrp_deck.sv
module wrp_deck (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wrp_pkg::t_deck_ctl          i_ctl,
    output logic [wrp_pkg::DECK_AW-1:0] o_qa,
    output logic [wrp_pkg::DECK_AW-1:0] o_qb
);

    logic [wrp_pkg::DECK_AW-1:0] mem [wrp_pkg::MAX_CLUSTER_SERVERS];
    logic [wrp_pkg::MAX_CLUSTER_SERVERS-1:0] r_vld;
    logic [wrp_pkg::DECK_AW-1:0] r_qa;
    logic [wrp_pkg::DECK_AW-1:0] r_qb;
    logic [wrp_pkg::DECK_AW-1:0] r_aa;
    logic [wrp_pkg::DECK_AW-1:0] r_ab;
    logic                        r_va;
    logic                        r_vb;

    // an entry never written since the last clear holds its own position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld <= '0;
        end else if (i_ctl.we) begin
            r_vld[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        if (i_ctl.re) begin
            r_qa <= mem[i_ctl.ra];
            r_qb <= mem[i_ctl.rb];
            r_aa <= i_ctl.ra;
            r_ab <= i_ctl.rb;
            r_va <= r_vld[i_ctl.ra];
            r_vb <= r_vld[i_ctl.rb];
        end
    end

    assign o_qa = r_va ? r_qa : r_aa;
    assign o_qb = r_vb ? r_qb : r_ab;

endmodule

// File: rtl/core/weighted_replica_placement.sv
// Add: multiply, table write, then the result register.
// Place: hash, then per visited cluster read, read wait, setup, draw close and
// advance, a deck seed step when the cluster takes replicas, random step,
// multiply and compare per weighted draw, and random step, multiply, deck read
// and emit per chosen server, plus any output stall; draws and picks share the
// single MWC generator. One item at a time; i_in.ready is high only between
// items. Reset (synchronous, active low) empties the cluster table and the output.
module weighted_replica_placement (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wrp_in_if.sink    i_in,
    wrp_out_if.source o_out
);

    wrp_pkg::t_state r_state, n_state;

    // output register
    logic        r_ovld, n_ovld;
    logic [11:0] r_oidx, n_oidx;
    logic [4:0]  r_otot, n_otot;
    logic [1:0]  r_ost, n_ost;
    logic        r_olast, n_olast;

    // table bookkeeping
    logic [4:0]  r_used, n_used;
    logic [12:0] r_stotal, n_stotal;
    logic [27:0] r_wsum, n_wsum;

    // item working registers
    logic [8:0]  r_asz, n_asz;
    logic [15:0] r_aw, n_aw;
    logic [24:0] r_aprod, n_aprod;
    logic [1:0]  r_st, n_st;
    logic [4:0]  r_tot, n_tot;
    logic [31:0] r_key, n_key;
    logic [31:0] r_hash, n_hash;
    logic [4:0]  r_left, n_left;
    logic [wrp_pkg::CL_AW-1:0] r_c, n_c;
    logic [8:0]  r_sz, n_sz;
    logic [15:0] r_w, n_w;
    logic [11:0] r_prev, n_prev;
    logic [27:0] r_wb, n_wb;
    logic [24:0] r_yes, n_yes;
    logic [27:0] r_total, n_total;
    logic [4:0]  r_must, n_must;
    logic [4:0]  r_draw, n_draw;
    logic [4:0]  r_pos, n_pos;
    logic [4:0]  r_i, n_i;
    logic [4:0]  r_n, n_n;
    logic [59:0] r_prod, n_prod;
    logic [wrp_pkg::DECK_AW-1:0] r_pick, n_pick;

    wrp_pkg::t_ctab_ctl ctab_ctl;
    wrp_pkg::t_centry   ctab_q;
    wrp_pkg::t_rng_ctl  rng_ctl;
    wrp_pkg::t_deck_ctl deck_ctl;
    logic [31:0] rnd;
    logic [wrp_pkg::DECK_AW-1:0] deck_qa, deck_qb;

    logic        can_load;
    logic [8:0]  m;
    logic [40:0] pick_prod;
    logic signed [10:0] d0, lim, dsel;
    logic [5:0]  nsum;
    logic [8:0]  nclamp;
    logic [31:0] cl_ext;

    wrp_ctab u_ctab (
        .i_clk  (i_clk),
        .i_ctl  (ctab_ctl),
        .o_rdata(ctab_q)
    );

    wrp_mwc u_mwc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (rng_ctl),
        .o_rnd  (rnd)
    );

    wrp_deck u_deck (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (deck_ctl),
        .o_qa   (deck_qa),
        .o_qb   (deck_qb)
    );

    assign can_load = !r_ovld || o_out.ready;
    // servers still in the deck for this pick
    assign m         = r_sz - {4'd0, r_i};
    assign pick_prod = rnd * m;
    assign cl_ext    = {{(32-wrp_pkg::CL_AW){1'b0}}, r_c};

    assign i_in.ready          = (r_state == wrp_pkg::S_IDLE);
    assign o_out.valid         = r_ovld;
    assign o_out.server_index  = r_oidx;
    assign o_out.cluster_total = r_otot;
    assign o_out.status        = r_ost;
    assign o_out.last          = r_olast;

    always_comb begin
        n_state = r_state;
        n_ovld  = r_ovld && !o_out.ready;
        n_oidx  = r_oidx;
        n_otot  = r_otot;
        n_ost   = r_ost;
        n_olast = r_olast;
        n_used  = r_used;
        n_stotal = r_stotal;
        n_wsum  = r_wsum;
        n_asz   = r_asz;
        n_aw    = r_aw;
        n_aprod = r_aprod;
        n_st    = r_st;
        n_tot   = r_tot;
        n_key   = r_key;
        n_hash  = r_hash;
        n_left  = r_left;
        n_c     = r_c;
        n_sz    = r_sz;
        n_w     = r_w;
        n_prev  = r_prev;
        n_wb    = r_wb;
        n_yes   = r_yes;
        n_total = r_total;
        n_must  = r_must;
        n_draw  = r_draw;
        n_pos   = r_pos;
        n_i     = r_i;
        n_n     = r_n;
        n_prod  = r_prod;
        n_pick  = r_pick;

        ctab_ctl       = '0;
        ctab_ctl.raddr = r_c;
        ctab_ctl.waddr = r_used[wrp_pkg::CL_AW-1:0];
        ctab_ctl.wdata = '{sz: r_asz, w: r_aw, sb: r_stotal[11:0], wb: r_wsum};
        rng_ctl        = '0;
        deck_ctl       = '0;
        deck_ctl.ra    = r_pick;
        deck_ctl.rb    = 8'(m - 9'd1);
        deck_ctl.waddr = r_pick;
        deck_ctl.wdata = deck_qb;

        d0     = $signed({6'd0, r_left}) - $signed({6'd0, r_must});
        lim    = $signed({2'd0, r_sz}) - $signed({6'd0, r_must});
        dsel   = (d0 > lim) ? lim : d0;
        nsum   = {1'b0, r_must} + {1'b0, r_pos};
        nclamp = ({3'd0, nsum} > r_sz) ? r_sz : {3'd0, nsum};

        unique case (r_state)
            wrp_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.action == wrp_pkg::ACT_ADD) begin
                        if (r_used == 5'(wrp_pkg::MAX_CLUSTERS)) begin
                            // table full: report and change nothing
                            n_st    = wrp_pkg::ST_FULL;
                            n_tot   = r_used;
                            n_state = wrp_pkg::S_EMIT;
                        end else begin
                            n_asz   = (i_in.cluster_servers > 9'(wrp_pkg::MAX_CLUSTER_SERVERS))
                                      ? 9'(wrp_pkg::MAX_CLUSTER_SERVERS) : i_in.cluster_servers;
                            n_aw    = i_in.server_weight;
                            n_state = wrp_pkg::S_ADD_MUL;
                        end
                    end else begin
                        n_key  = i_in.key;
                        n_left = i_in.replica_count;
                        n_c    = wrp_pkg::CL_AW'(r_used - 5'd1);
                        if ({8'd0, i_in.replica_count} > r_stotal ||
                            i_in.replica_count > 5'(wrp_pkg::MAX_REPLICAS)) begin
                            n_st    = wrp_pkg::ST_TOO_MANY;
                            n_tot   = 5'd0;
                            n_state = wrp_pkg::S_EMIT;
                        end else if (i_in.replica_count != 5'd0) begin
                            n_state = wrp_pkg::S_HASH;
                        end
                    end
                end
            end
            wrp_pkg::S_EMIT: begin
                if (can_load) begin
                    n_ovld  = 1'b1;
                    n_oidx  = 12'd0;
                    n_otot  = r_tot;
                    n_ost   = r_st;
                    n_olast = 1'b1;
                    n_state = wrp_pkg::S_IDLE;
                end
            end
            wrp_pkg::S_ADD_MUL: begin
                n_aprod = r_asz * r_aw;
                n_state = wrp_pkg::S_ADD_WR;
            end
            wrp_pkg::S_ADD_WR: begin
                // entry records the servers and weight of all older clusters
                ctab_ctl.we = 1'b1;
                n_used   = r_used + 5'd1;
                n_stotal = r_stotal + {4'd0, r_asz};
                n_wsum   = r_wsum + {3'd0, r_aprod};
                n_st     = wrp_pkg::ST_ADDED;
                n_tot    = r_used + 5'd1;
                n_state  = wrp_pkg::S_EMIT;
            end
            wrp_pkg::S_HASH: begin
                n_hash  = 32'((r_key ^ wrp_pkg::HASH_XOR) * wrp_pkg::HASH_MUL);
                n_state = wrp_pkg::S_CL_RD;
            end
            wrp_pkg::S_CL_RD: begin
                n_state = wrp_pkg::S_CL_WAIT;
            end
            wrp_pkg::S_CL_WAIT: begin
                n_sz    = ctab_q.sz;
                n_w     = ctab_q.w;
                n_prev  = ctab_q.sb;
                n_wb    = ctab_q.wb;
                n_yes   = ctab_q.sz * ctab_q.w;
                // replicas the older clusters cannot hold land here for sure
                n_must  = (ctab_q.sb < {7'd0, r_left}) ? 5'({7'd0, r_left} - ctab_q.sb) : 5'd0;
                n_state = wrp_pkg::S_CL_SETUP;
            end
            wrp_pkg::S_CL_SETUP: begin
                n_total = r_wb + {3'd0, r_yes};
                n_draw  = (dsel < 0) ? 5'd0 : 5'(dsel);
                n_pos   = 5'd0;
                n_i     = 5'd0;
                rng_ctl.seed = 1'b1;
                rng_ctl.a    = r_hash ^ cl_ext;
                rng_ctl.b    = cl_ext ^ wrp_pkg::DRAW_SALT;
                if (r_w == 16'd0 || dsel <= 0) begin
                    n_state = wrp_pkg::S_DR_DONE;
                end else begin
                    n_state = wrp_pkg::S_DR_RNG;
                end
            end
            wrp_pkg::S_DR_RNG: begin
                rng_ctl.step = 1'b1;
                n_state = wrp_pkg::S_DR_MUL;
            end
            wrp_pkg::S_DR_MUL: begin
                n_prod  = rnd * r_total;
                n_state = wrp_pkg::S_DR_CMP;
            end
            wrp_pkg::S_DR_CMP: begin
                // success when rand * total < yes * 2^32
                if (r_prod < {3'd0, r_yes, 32'd0}) begin
                    n_pos = r_pos + 5'd1;
                    n_yes = (r_yes >= {9'd0, r_w}) ? r_yes - {9'd0, r_w} : 25'd0;
                end
                n_total = (r_total >= {12'd0, r_w}) ? r_total - {12'd0, r_w} : 28'd0;
                n_i     = r_i + 5'd1;
                n_state = (r_i + 5'd1 == r_draw) ? wrp_pkg::S_DR_DONE : wrp_pkg::S_DR_RNG;
            end
            wrp_pkg::S_DR_DONE: begin
                n_n = (nclamp > {4'd0, r_left}) ? r_left : 5'(nclamp);
                if (nclamp == 9'd0) begin
                    n_state = wrp_pkg::S_NEXT;
                end else begin
                    n_state = wrp_pkg::S_PK_SEED;
                end
            end
            wrp_pkg::S_PK_SEED: begin
                // fresh deck: every slot reads as its own position
                deck_ctl.clr = 1'b1;
                rng_ctl.seed = 1'b1;
                rng_ctl.a    = r_hash ^ cl_ext ^ wrp_pkg::PICK_KEY_XOR;
                rng_ctl.b    = cl_ext ^ wrp_pkg::PICK_SALT;
                n_i     = 5'd0;
                n_state = wrp_pkg::S_PK_RNG;
            end
            wrp_pkg::S_PK_RNG: begin
                rng_ctl.step = 1'b1;
                n_state = wrp_pkg::S_PK_MUL;
            end
            wrp_pkg::S_PK_MUL: begin
                n_pick  = pick_prod[32 +: wrp_pkg::DECK_AW];
                n_state = wrp_pkg::S_PK_RD;
            end
            wrp_pkg::S_PK_RD: begin
                deck_ctl.re = 1'b1;
                n_state = wrp_pkg::S_PK_EMIT;
            end
            wrp_pkg::S_PK_EMIT: begin
                if (can_load) begin
                    n_ovld  = 1'b1;
                    n_oidx  = {4'd0, deck_qa} + r_prev;
                    n_otot  = 5'd0;
                    n_ost   = wrp_pkg::ST_SERVER;
                    n_olast = (r_left == 5'd1);
                    // move the tail entry into the chosen slot
                    deck_ctl.we = 1'b1;
                    n_left  = r_left - 5'd1;
                    n_i     = r_i + 5'd1;
                    n_state = (r_i + 5'd1 == r_n) ? wrp_pkg::S_NEXT : wrp_pkg::S_PK_RNG;
                end
            end
            wrp_pkg::S_NEXT: begin
                if (r_left == 5'd0 || r_c == '0) begin
                    n_state = wrp_pkg::S_IDLE;
                end else begin
                    n_c     = r_c - 1'b1;
                    n_state = wrp_pkg::S_CL_RD;
                end
            end
            default: n_state = wrp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wrp_pkg::S_IDLE;
            r_ovld   <= 1'b0;
            r_used   <= 5'd0;
            r_stotal <= 13'd0;
            r_wsum   <= 28'd0;
        end else begin
            r_state  <= n_state;
            r_ovld   <= n_ovld;
            r_used   <= n_used;
            r_stotal <= n_stotal;
            r_wsum   <= n_wsum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oidx  <= n_oidx;
        r_otot  <= n_otot;
        r_ost   <= n_ost;
        r_olast <= n_olast;
        r_asz   <= n_asz;
        r_aw    <= n_aw;
        r_aprod <= n_aprod;
        r_st    <= n_st;
        r_tot   <= n_tot;
        r_key   <= n_key;
        r_hash  <= n_hash;
        r_left  <= n_left;
        r_c     <= n_c;
        r_sz    <= n_sz;
        r_w     <= n_w;
        r_prev  <= n_prev;
        r_wb    <= n_wb;
        r_yes   <= n_yes;
        r_total <= n_total;
        r_must  <= n_must;
        r_draw  <= n_draw;
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_n     <= n_n;
        r_prod  <= n_prod;
        r_pick  <= n_pick;
    end

    // every non-server result closes its item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != wrp_pkg::ST_SERVER |-> o_out.last)
        else $error("non-server result without last");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= 5'(wrp_pkg::MAX_CLUSTERS))
        else $error("cluster count past table depth");

    // a shuffle pick stays inside the remaining deck
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wrp_pkg::S_PK_RD |-> {1'b0, r_pick} < m)
        else $error("pick outside remaining deck");

    a_left_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wrp_pkg::S_PK_EMIT && can_load |=> r_left == $past(r_left) - 5'd1)
        else $error("replica count not consumed on server result");

endmodule
